### hdl/dcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_pkg
// Widths, limits and transfer sideband types of the distance constraint
// projection pipeline.
// ----------------------------------------------------------------------------
package dcp_pkg;

   localparam int POS_W    = 24;
   localparam int MASS_W   = 16;
   localparam int REST_W   = 23;
   localparam int DIFF_W   = POS_W + 1;
   localparam int SQ_W     = 2 * POS_W;
   localparam int SUM_W    = SQ_W + 2;
   localparam int ROOT_W   = SUM_W / 2;
   localparam int ERR_W    = ROOT_W + 2;
   localparam int D1_QUO_W = 27;
   localparam int D1_DEN_W = ROOT_W;
   localparam int PROD_W   = D1_DEN_W + D1_QUO_W;
   localparam int T_W      = D1_QUO_W + 1;
   localparam int WSUM_W   = MASS_W + 1;
   localparam int MT_W     = T_W + WSUM_W;
   localparam int D2_QUO_W = 27;
   localparam int D2_DEN_W = WSUM_W + 3;
   localparam int SC_W     = D2_DEN_W + D2_QUO_W;
   localparam int C_W      = D2_QUO_W + 1;
   localparam int FIN_W    = C_W + 1;
   localparam int LANES1   = 3;
   localparam int LANES2   = 2 * LANES1;

   localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   typedef logic [POS_W-1:0] pos_type;

   typedef struct packed {
      pos_type [2:0]               a;
      pos_type [2:0]               b;
      logic [2:0][DIFF_W-1:0]      d;
      logic [MASS_W-1:0]           w1;
      logic [MASS_W-1:0]           w2;
      logic [REST_W-1:0]           rest;
      logic                        bend;
      logic                        deg;
   } root_side_type;

   typedef struct packed {
      pos_type [2:0]               a;
      pos_type [2:0]               b;
      logic [MASS_W-1:0]           w1;
      logic [MASS_W-1:0]           w2;
      logic                        bend;
      logic                        deg;
      logic [LANES1-1:0]           neg;
   } quo1_side_type;

   typedef struct packed {
      pos_type [2:0]               a;
      pos_type [2:0]               b;
      logic                        deg;
      logic [LANES2-1:0]           neg;
   } quo2_side_type;

   typedef struct packed {
      pos_type [2:0]               first;
      pos_type [2:0]               second;
      logic                        deg;
   } result_type;

endpackage

### hdl/distance_constraint_projection_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_constraint_projection_unit
// Distance constraint projection: moves two particles along their joining
// line toward a rest length, shared by inverse mass.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one constraint per transfer: two Q7.16 positions, two Q4.12
//   inverse masses, a rest length and the bending mode bit. rsp_ returns one
//   result per constraint, in order: the corrected positions and the
//   degenerate flag (zero mass sum or coincident points, positions passed).
//   Between a req_ transfer and rsp_valid lie the square root (25 stages)
//   and the two dividers (27 stages each), plus the multiply, round and
//   saturate stages.
//   Throughput is one constraint per cycle while req_stall is low.
//   rsp_ has an output register and a one-entry skid buffer. When the
//   receiver stalls a waiting result, the next one goes into the skid
//   buffer, and while it is full the whole pipeline holds and req_stall is
//   high; nothing is dropped or repeated.
//   Reset clears all valid bits; the pipeline is empty and ready at once.
// ----------------------------------------------------------------------------
module distance_constraint_projection_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dcp_pkg::POS_W-1:0]    req_first_x,
   input  logic [dcp_pkg::POS_W-1:0]    req_first_y,
   input  logic [dcp_pkg::POS_W-1:0]    req_first_z,
   input  logic [dcp_pkg::POS_W-1:0]    req_second_x,
   input  logic [dcp_pkg::POS_W-1:0]    req_second_y,
   input  logic [dcp_pkg::POS_W-1:0]    req_second_z,
   input  logic [dcp_pkg::MASS_W-1:0]   req_first_inv_mass,
   input  logic [dcp_pkg::MASS_W-1:0]   req_second_inv_mass,
   input  logic [dcp_pkg::REST_W-1:0]   req_rest_length,
   input  logic                         req_bending_mode,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dcp_pkg::POS_W-1:0]    rsp_new_first_x,
   output logic [dcp_pkg::POS_W-1:0]    rsp_new_first_y,
   output logic [dcp_pkg::POS_W-1:0]    rsp_new_first_z,
   output logic [dcp_pkg::POS_W-1:0]    rsp_new_second_x,
   output logic [dcp_pkg::POS_W-1:0]    rsp_new_second_y,
   output logic [dcp_pkg::POS_W-1:0]    rsp_new_second_z,
   output logic                         rsp_degenerate
);

   localparam int POS_W    = dcp_pkg::POS_W;
   localparam int DIFF_W   = dcp_pkg::DIFF_W;
   localparam int SQ_W     = dcp_pkg::SQ_W;
   localparam int SUM_W    = dcp_pkg::SUM_W;
   localparam int ROOT_W   = dcp_pkg::ROOT_W;
   localparam int ERR_W    = dcp_pkg::ERR_W;
   localparam int REST_W   = dcp_pkg::REST_W;
   localparam int PROD_W   = dcp_pkg::PROD_W;
   localparam int D1_QUO_W = dcp_pkg::D1_QUO_W;
   localparam int T_W      = dcp_pkg::T_W;
   localparam int WSUM_W   = dcp_pkg::WSUM_W;
   localparam int MT_W     = dcp_pkg::MT_W;
   localparam int SC_W     = dcp_pkg::SC_W;
   localparam int D2_DEN_W = dcp_pkg::D2_DEN_W;
   localparam int D2_QUO_W = dcp_pkg::D2_QUO_W;
   localparam int C_W      = dcp_pkg::C_W;
   localparam int FIN_W    = dcp_pkg::FIN_W;
   localparam int LANES1   = dcp_pkg::LANES1;
   localparam int LANES2   = dcp_pkg::LANES2;

   function automatic logic [POS_W-1:0] sat_pos(input logic [FIN_W-1:0] v);
      logic upper_ones;
      logic upper_zeros;
      upper_ones  = &v[FIN_W-1:POS_W-1];
      upper_zeros = ~(|v[FIN_W-1:POS_W-1]);
      if (upper_ones || upper_zeros) begin
         sat_pos = v[POS_W-1:0];
      end else if (v[FIN_W-1]) begin
         sat_pos = dcp_pkg::POS_MIN;
      end else begin
         sat_pos = dcp_pkg::POS_MAX;
      end
   endfunction

   logic en;

   // difference and degenerate check
   dcp_pkg::root_side_type s1_in, s1_ff;
   logic                   s1_valid_ff;

   // squares
   dcp_pkg::root_side_type      s2_ff;
   logic [2:0][SQ_W-1:0]        sq_in, sq_ff;
   logic                        s2_valid_ff;

   // sum of squares
   dcp_pkg::root_side_type      s3_ff;
   logic [SUM_W-1:0]            sum_in, sum_ff;
   logic                        s3_valid_ff;

   logic                        root_valid;
   logic [ROOT_W-1:0]           root_len;
   dcp_pkg::root_side_type      root_side;

   // length error
   dcp_pkg::root_side_type      p1_ff;
   logic [ERR_W-1:0]            err_in, err_ff;
   logic [ROOT_W-1:0]           len1_ff;
   logic                        p1_valid_ff;

   // error times separation
   dcp_pkg::root_side_type      p2_ff;
   logic [2:0][PROD_W-1:0]      prod_in, prod_ff;
   logic [ROOT_W-1:0]           len2_ff;
   logic                        p2_valid_ff;

   // magnitude with rounding bias
   dcp_pkg::quo1_side_type      p3_in, p3_ff;
   logic [LANES1-1:0][PROD_W-1:0] mag1_in, mag1_ff;
   logic [ROOT_W-1:0]           len3_ff;
   logic                        p3_valid_ff;

   logic                                 quo1_valid;
   logic [LANES1-1:0][D1_QUO_W-1:0]      quo1;
   dcp_pkg::quo1_side_type               quo1_side;

   // signed scaled offset
   dcp_pkg::quo1_side_type      t_ff;
   logic [2:0][T_W-1:0]         t_in, t_val_ff;
   logic                        t_valid_ff;

   // mass products
   dcp_pkg::quo1_side_type      m1_ff;
   logic [LANES2-1:0][MT_W-1:0] mp_in, mp_ff;
   logic [WSUM_W-1:0]           wsum_in, wsum_ff;
   logic                        m1_valid_ff;

   // bending scale
   dcp_pkg::quo1_side_type      m2_ff;
   logic [LANES2-1:0][SC_W-1:0] sc_in, sc_ff;
   logic [D2_DEN_W-1:0]         den2_in, den2_ff;
   logic                        m2_valid_ff;

   // magnitude with rounding bias
   dcp_pkg::quo2_side_type      m3_in, m3_ff;
   logic [LANES2-1:0][SC_W-1:0] mag2_in, mag2_ff;
   logic [D2_DEN_W-1:0]         den3_ff;
   logic                        m3_valid_ff;

   logic                                 quo2_valid;
   logic [LANES2-1:0][D2_QUO_W-1:0]      quo2;
   dcp_pkg::quo2_side_type               quo2_side;

   // correction and saturation
   dcp_pkg::result_type         fin_in, fin_ff;
   logic                        fin_valid_ff;

   // output register and skid
   dcp_pkg::result_type         rsp_in, rsp_ff, skid_ff;
   logic                        rsp_valid_in, rsp_valid_ff;
   logic                        skid_valid_in, skid_valid_ff;
   logic                        rsp_load, skid_load;

   assign en        = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // stage 1
   always_comb begin
      s1_in.a[0] = req_first_x;
      s1_in.a[1] = req_first_y;
      s1_in.a[2] = req_first_z;
      s1_in.b[0] = req_second_x;
      s1_in.b[1] = req_second_y;
      s1_in.b[2] = req_second_z;
      for (int i = 0; i < 3; i++) begin
         s1_in.d[i] = {s1_in.a[i][POS_W-1], s1_in.a[i]} - {s1_in.b[i][POS_W-1], s1_in.b[i]};
      end
      s1_in.w1   = req_first_inv_mass;
      s1_in.w2   = req_second_inv_mass;
      s1_in.rest = req_rest_length;
      s1_in.bend = req_bending_mode;
      s1_in.deg  = ((req_first_inv_mass == '0) && (req_second_inv_mass == '0))
                   || (s1_in.a == s1_in.b);
   end

   // stage 2
   always_comb begin
      logic signed [2*DIFF_W-1:0] sq_full;
      for (int i = 0; i < 3; i++) begin
         sq_full  = (2*DIFF_W)'($signed(s1_ff.d[i])) * (2*DIFF_W)'($signed(s1_ff.d[i]));
         sq_in[i] = sq_full[SQ_W-1:0];
      end
   end

   // stage 3
   assign sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= s1_in;
         s2_ff  <= s1_ff;
         sq_ff  <= sq_in;
         s3_ff  <= s2_ff;
         sum_ff <= sum_in;
      end
   end

   dcp_sqrt #(
      .RAD_W  (SUM_W),
      .SIDE_W ($bits(dcp_pkg::root_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_rad    (sum_ff),
      .in_side   (s3_ff),
      .out_valid (root_valid),
      .out_root  (root_len),
      .out_side  (root_side)
   );

   assign err_in = $signed({{(ERR_W-ROOT_W){1'b0}}, root_len})
                 - $signed({{(ERR_W-REST_W){1'b0}}, root_side.rest});

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = PROD_W'($signed(err_ff)) * PROD_W'($signed(p1_ff.d[i]));
      end
   end

   always_comb begin
      logic [PROD_W-1:0] abs_v;
      p3_in.a    = p2_ff.a;
      p3_in.b    = p2_ff.b;
      p3_in.w1   = p2_ff.w1;
      p3_in.w2   = p2_ff.w2;
      p3_in.bend = p2_ff.bend;
      p3_in.deg  = p2_ff.deg;
      for (int i = 0; i < LANES1; i++) begin
         p3_in.neg[i] = prod_ff[i][PROD_W-1];
         abs_v        = prod_ff[i][PROD_W-1] ? (~prod_ff[i] + 1'b1) : prod_ff[i];
         mag1_in[i]   = abs_v + PROD_W'(len2_ff >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= root_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff   <= root_side;
         err_ff  <= err_in;
         len1_ff <= root_len;
         p2_ff   <= p1_ff;
         prod_ff <= prod_in;
         len2_ff <= len1_ff;
         p3_ff   <= p3_in;
         mag1_ff <= mag1_in;
         len3_ff <= len2_ff;
      end
   end

   dcp_div #(
      .LANES  (LANES1),
      .DEN_W  (ROOT_W),
      .QUO_W  (D1_QUO_W),
      .SIDE_W ($bits(dcp_pkg::quo1_side_type))
   ) u_div_len (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p3_valid_ff),
      .in_num    (mag1_ff),
      .in_den    (len3_ff),
      .in_side   (p3_ff),
      .out_valid (quo1_valid),
      .out_quo   (quo1),
      .out_side  (quo1_side)
   );

   always_comb begin
      logic [T_W-1:0] qx;
      for (int i = 0; i < LANES1; i++) begin
         qx      = {1'b0, quo1[i]};
         t_in[i] = quo1_side.neg[i] ? (~qx + 1'b1) : qx;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mp_in[i]   = MT_W'($signed(t_val_ff[i])) * MT_W'($signed({1'b0, t_ff.w1}));
         mp_in[3+i] = MT_W'($signed(t_val_ff[i])) * MT_W'($signed({1'b0, t_ff.w2}));
      end
      wsum_in = WSUM_W'(t_ff.w1) + WSUM_W'(t_ff.w2);
   end

   always_comb begin
      logic [SC_W-1:0]     sx;
      logic [D2_DEN_W-1:0] dw;
      for (int j = 0; j < LANES2; j++) begin
         sx       = {{(SC_W-MT_W){mp_ff[j][MT_W-1]}}, mp_ff[j]};
         sc_in[j] = m1_ff.bend ? ((sx << 1) + sx) : sx;
      end
      dw      = D2_DEN_W'(wsum_ff);
      den2_in = m1_ff.bend ? ((dw << 2) + dw) : dw;
   end

   always_comb begin
      logic [SC_W-1:0] abs_v;
      m3_in.a   = m2_ff.a;
      m3_in.b   = m2_ff.b;
      m3_in.deg = m2_ff.deg;
      for (int j = 0; j < LANES2; j++) begin
         m3_in.neg[j] = sc_ff[j][SC_W-1];
         abs_v        = sc_ff[j][SC_W-1] ? (~sc_ff[j] + 1'b1) : sc_ff[j];
         mag2_in[j]   = abs_v + SC_W'(den2_ff >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff  <= 1'b0;
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
      end else if (en) begin
         t_valid_ff  <= quo1_valid;
         m1_valid_ff <= t_valid_ff;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff     <= quo1_side;
         t_val_ff <= t_in;
         m1_ff    <= t_ff;
         mp_ff    <= mp_in;
         wsum_ff  <= wsum_in;
         m2_ff    <= m1_ff;
         sc_ff    <= sc_in;
         den2_ff  <= den2_in;
         m3_ff    <= m3_in;
         mag2_ff  <= mag2_in;
         den3_ff  <= den2_ff;
      end
   end

   dcp_div #(
      .LANES  (LANES2),
      .DEN_W  (D2_DEN_W),
      .QUO_W  (D2_QUO_W),
      .SIDE_W ($bits(dcp_pkg::quo2_side_type))
   ) u_div_mass (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m3_valid_ff),
      .in_num    (mag2_ff),
      .in_den    (den3_ff),
      .in_side   (m3_ff),
      .out_valid (quo2_valid),
      .out_quo   (quo2),
      .out_side  (quo2_side)
   );

   // first moves against the separation, second with it
   always_comb begin
      logic [C_W-1:0]   qx;
      logic [C_W-1:0]   c1;
      logic [C_W-1:0]   c2;
      logic [FIN_W-1:0] v1;
      logic [FIN_W-1:0] v2;
      for (int i = 0; i < 3; i++) begin
         qx = {1'b0, quo2[i]};
         c1 = quo2_side.neg[i] ? (~qx + 1'b1) : qx;
         qx = {1'b0, quo2[3+i]};
         c2 = quo2_side.neg[3+i] ? (~qx + 1'b1) : qx;
         v1 = {{(FIN_W-POS_W){quo2_side.a[i][POS_W-1]}}, quo2_side.a[i]}
            - {c1[C_W-1], c1};
         v2 = {{(FIN_W-POS_W){quo2_side.b[i][POS_W-1]}}, quo2_side.b[i]}
            + {c2[C_W-1], c2};
         if (quo2_side.deg) begin
            fin_in.first[i]  = quo2_side.a[i];
            fin_in.second[i] = quo2_side.b[i];
         end else begin
            fin_in.first[i]  = sat_pos(v1);
            fin_in.second[i] = sat_pos(v2);
         end
      end
      fin_in.deg = quo2_side.deg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= quo2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_ff <= fin_in;
      end
   end

   // output register and skid control
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_load      = 1'b0;
      skid_load     = 1'b0;
      rsp_in        = fin_ff;
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            rsp_load      = 1'b1;
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_load     = 1'b1;
         rsp_valid_in = fin_valid_ff;
      end else if (fin_valid_ff) begin
         skid_load     = 1'b1;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      if (skid_load) begin
         skid_ff <= fin_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_first_x  = rsp_ff.first[0];
   assign rsp_new_first_y  = rsp_ff.first[1];
   assign rsp_new_first_z  = rsp_ff.first[2];
   assign rsp_new_second_x = rsp_ff.second[0];
   assign rsp_new_second_y = rsp_ff.second[1];
   assign rsp_new_second_z = rsp_ff.second[2];
   assign rsp_degenerate   = rsp_ff.deg;

endmodule

### hdl/dcp_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_sqrt
// Pipelined integer square root, one root bit per register stage, with a
// sideband that travels alongside.
// ----------------------------------------------------------------------------
module dcp_sqrt #(
   parameter int RAD_W  = dcp_pkg::SUM_W,
   parameter int SIDE_W = $bits(dcp_pkg::root_side_type)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [RAD_W-1:0]    in_rad,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [RAD_W/2-1:0]  out_root,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic [ROOT_W-1:0] valid_ff;
   logic [ROOT_W-1:0] valid_in;
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [RAD_W-1:0]  rad_in  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];
   logic [SIDE_W-1:0] side_in [ROOT_W];

   always_comb begin
      logic              valid_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      for (int g = 0; g < ROOT_W; g++) begin
         if (g == 0) begin
            valid_prev = in_valid;
            rad_prev   = in_rad;
            rem_prev   = '0;
            root_prev  = '0;
            side_prev  = in_side;
         end else begin
            valid_prev = valid_ff[g-1];
            rad_prev   = rad_ff[g-1];
            rem_prev   = rem_ff[g-1];
            root_prev  = root_ff[g-1];
            side_prev  = side_ff[g-1];
         end
         rem_sh = {rem_prev[REM_W-3:0], rad_prev[2*(ROOT_W-1-g) +: 2]};
         trial  = {root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in[g]  = rem_sh - trial;
            root_in[g] = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[g]  = rem_sh;
            root_in[g] = {root_prev[ROOT_W-2:0], 1'b0};
         end
         valid_in[g] = valid_prev;
         rad_in[g]   = rad_prev;
         side_in[g]  = side_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

### hdl/dcp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_div
// Pipelined restoring divider, one quotient bit per register stage, several
// lanes over a shared divisor, with a sideband that travels alongside.
// ----------------------------------------------------------------------------
module dcp_div #(
   parameter int LANES  = dcp_pkg::LANES1,
   parameter int DEN_W  = dcp_pkg::D1_DEN_W,
   parameter int QUO_W  = dcp_pkg::D1_QUO_W,
   parameter int SIDE_W = $bits(dcp_pkg::quo1_side_type)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [LANES-1:0][DEN_W+QUO_W-1:0]    in_num,
   input  logic [DEN_W-1:0]                     in_den,
   input  logic [SIDE_W-1:0]                    in_side,
   output logic                                 out_valid,
   output logic [LANES-1:0][QUO_W-1:0]          out_quo,
   output logic [SIDE_W-1:0]                    out_side
);

   localparam int NUM_W = DEN_W + QUO_W;

   logic [QUO_W-1:0]              valid_ff;
   logic [QUO_W-1:0]              valid_in;
   logic [LANES-1:0][NUM_W-1:0]   rem_ff  [QUO_W];
   logic [LANES-1:0][NUM_W-1:0]   rem_in  [QUO_W];
   logic [LANES-1:0][QUO_W-1:0]   quo_ff  [QUO_W];
   logic [LANES-1:0][QUO_W-1:0]   quo_in  [QUO_W];
   logic [DEN_W-1:0]              den_ff  [QUO_W];
   logic [DEN_W-1:0]              den_in  [QUO_W];
   logic [SIDE_W-1:0]             side_ff [QUO_W];
   logic [SIDE_W-1:0]             side_in [QUO_W];

   always_comb begin
      logic                        valid_prev;
      logic [LANES-1:0][NUM_W-1:0] rem_prev;
      logic [LANES-1:0][QUO_W-1:0] quo_prev;
      logic [DEN_W-1:0]            den_prev;
      logic [SIDE_W-1:0]           side_prev;
      logic [NUM_W-1:0]            dsh;
      for (int g = 0; g < QUO_W; g++) begin
         if (g == 0) begin
            valid_prev = in_valid;
            rem_prev   = in_num;
            quo_prev   = '0;
            den_prev   = in_den;
            side_prev  = in_side;
         end else begin
            valid_prev = valid_ff[g-1];
            rem_prev   = rem_ff[g-1];
            quo_prev   = quo_ff[g-1];
            den_prev   = den_ff[g-1];
            side_prev  = side_ff[g-1];
         end
         dsh = NUM_W'(den_prev) << (QUO_W - 1 - g);
         for (int l = 0; l < LANES; l++) begin
            if (rem_prev[l] >= dsh) begin
               rem_in[g][l] = rem_prev[l] - dsh;
               quo_in[g][l] = {quo_prev[l][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[g][l] = rem_prev[l];
               quo_in[g][l] = {quo_prev[l][QUO_W-2:0], 1'b0};
            end
         end
         valid_in[g] = valid_prev;
         den_in[g]   = den_prev;
         side_in[g]  = side_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for distance_constraint_projection_unit: directed and
// random constraints go in through a bursty driver, results are compared
// field by field against an in-bench projection model, in order.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 200;

   typedef logic [dcp_pkg::MASS_W-1:0] mass_type;
   typedef logic [dcp_pkg::REST_W-1:0] rest_type;

   typedef struct {
      dcp_pkg::pos_type [2:0] first;
      dcp_pkg::pos_type [2:0] second;
      mass_type               w1;
      mass_type               w2;
      rest_type               rest;
      logic                   bend;
      bit                     wait_drain;
   } constraint_type;

   typedef struct {
      dcp_pkg::pos_type [2:0] first;
      dcp_pkg::pos_type [2:0] second;
      logic                   deg;
   } projection_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   dcp_pkg::pos_type req_first_x = '0, req_first_y = '0, req_first_z = '0;
   dcp_pkg::pos_type req_second_x = '0, req_second_y = '0, req_second_z = '0;
   mass_type req_first_inv_mass = '0, req_second_inv_mass = '0;
   rest_type req_rest_length = '0;
   logic req_bending_mode = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   dcp_pkg::pos_type rsp_new_first_x, rsp_new_first_y, rsp_new_first_z;
   dcp_pkg::pos_type rsp_new_second_x, rsp_new_second_y, rsp_new_second_z;
   logic rsp_degenerate;

   constraint_type pending_constraints[$];
   projection_type expected_projections[$];
   constraint_type driven;
   int errors = 0;
   int received = 0;
   int cycles = 0;

   distance_constraint_projection_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint root_floor(longint v);
      longint res = 0;
      longint bitv = longint'(1) << 62;
      while (bitv > v) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >>> 1) + bitv;
         end else begin
            res = res >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return res;
   endfunction

   function automatic longint round_div(longint num, longint den);
      longint mag = (num < 0) ? -num : num;
      longint q = (mag + (den >>> 1)) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic dcp_pkg::pos_type clamp_pos(longint v);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return dcp_pkg::pos_type'(v);
   endfunction

   function automatic projection_type project(constraint_type c);
      projection_type p;
      longint a[3], b[3], d[3];
      longint s = 0, len, e, w1, w2, sn, sd, den, t, c1, c2;
      w1 = longint'(c.w1);
      w2 = longint'(c.w2);
      for (int i = 0; i < 3; i++) begin
         a[i] = longint'(signed'(c.first[i]));
         b[i] = longint'(signed'(c.second[i]));
         d[i] = a[i] - b[i];
         s += d[i] * d[i];
      end
      p.first = c.first;
      p.second = c.second;
      p.deg = 1'b1;
      if (w1 + w2 == 0 || s == 0) return p;
      len = root_floor(s);
      e = len - longint'(c.rest);
      sn = c.bend ? 64'sd3 : 64'sd1;
      sd = c.bend ? 64'sd5 : 64'sd1;
      den = (w1 + w2) * sd;
      for (int i = 0; i < 3; i++) begin
         t = round_div(e * d[i], len);
         c1 = round_div(t * w1 * sn, den);
         c2 = round_div(t * w2 * sn, den);
         p.first[i] = clamp_pos(a[i] - c1);
         p.second[i] = clamp_pos(b[i] + c2);
      end
      p.deg = 1'b0;
      return p;
   endfunction

   task automatic report(string what, int idx, longint got, longint want);
      $display("mismatch: result %0d %s got %h expected %h", idx, what, got, want);
      errors++;
   endtask

   function automatic void queue_constraint(constraint_type c);
      pending_constraints.insert(pending_constraints.size(), c);
   endfunction

   // driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      logic nv;
      bit accepted;
      accepted = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (accepted)
            expected_projections.insert(expected_projections.size(), project(driven));
         nv = req_valid && !accepted;
         if (!req_valid || accepted) begin
            nv = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_constraints.size() > 0 &&
                         !(pending_constraints[0].wait_drain &&
                           expected_projections.size() > 0)) begin
               driven = pending_constraints.pop_front();
               nv = 1'b1;
               {req_first_x, req_first_y, req_first_z} <=
                  {driven.first[0], driven.first[1], driven.first[2]};
               {req_second_x, req_second_y, req_second_z} <=
                  {driven.second[0], driven.second[1], driven.second[2]};
               req_first_inv_mass <= driven.w1;
               req_second_inv_mass <= driven.w2;
               req_rest_length <= driven.rest;
               req_bending_mode <= driven.bend;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(40, 1);
                  gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
               end
            end
         end
         req_valid <= nv;
      end
   end

   // receiver stall pattern, with one long hold-off
   int hold_left = 0;
   bit held = 1'b0;
   int stall_mode = 0;
   always @(posedge clock) begin
      if (!held && received >= 100) begin
         held = 1'b1;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if ($urandom_range(63, 0) == 0) stall_mode = $urandom_range(2, 0);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(3, 0) == 0);
            default: rsp_stall <= ($urandom_range(3, 0) != 0);
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      projection_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_projections.size() == 0) begin
            report("arrived with nothing expected", received, 0, 0);
         end else begin
            want = expected_projections.pop_front();
            if (rsp_new_first_x !== want.first[0])
               report("new_first_x", received, longint'(rsp_new_first_x),
                      longint'(want.first[0]));
            if (rsp_new_first_y !== want.first[1])
               report("new_first_y", received, longint'(rsp_new_first_y),
                      longint'(want.first[1]));
            if (rsp_new_first_z !== want.first[2])
               report("new_first_z", received, longint'(rsp_new_first_z),
                      longint'(want.first[2]));
            if (rsp_new_second_x !== want.second[0])
               report("new_second_x", received, longint'(rsp_new_second_x),
                      longint'(want.second[0]));
            if (rsp_new_second_y !== want.second[1])
               report("new_second_y", received, longint'(rsp_new_second_y),
                      longint'(want.second[1]));
            if (rsp_new_second_z !== want.second[2])
               report("new_second_z", received, longint'(rsp_new_second_z),
                      longint'(want.second[2]));
            if (rsp_degenerate !== want.deg)
               report("degenerate", received, longint'(rsp_degenerate),
                      longint'(want.deg));
         end
         received++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   function automatic constraint_type make_constraint(longint ax, longint ay, longint az,
         longint bx, longint by, longint bz, int w1, int w2, int rest, bit bend);
      constraint_type c;
      c.first[0] = dcp_pkg::pos_type'(ax);
      c.first[1] = dcp_pkg::pos_type'(ay);
      c.first[2] = dcp_pkg::pos_type'(az);
      c.second[0] = dcp_pkg::pos_type'(bx);
      c.second[1] = dcp_pkg::pos_type'(by);
      c.second[2] = dcp_pkg::pos_type'(bz);
      c.w1 = mass_type'(w1);
      c.w2 = mass_type'(w2);
      c.rest = rest_type'(rest);
      c.bend = bend;
      c.wait_drain = 1'b0;
      return c;
   endfunction

   function automatic constraint_type random_constraint();
      constraint_type c;
      int kind;
      longint spread;
      kind = $urandom_range(9, 0);
      spread = (kind < 6) ? (longint'(1) << $urandom_range(23, 4)) : (longint'(1) << 24);
      for (int i = 0; i < 3; i++) begin
         c.first[i] = dcp_pkg::pos_type'($urandom);
         if (kind < 6)
            c.second[i] = dcp_pkg::pos_type'(longint'(signed'(c.first[i])) +
                          longint'($urandom_range(int'(spread), 0)) - spread / 2);
         else
            c.second[i] = dcp_pkg::pos_type'($urandom);
      end
      if (kind == 6) c.second = c.first;
      c.w1 = mass_type'($urandom);
      c.w2 = mass_type'($urandom);
      if (kind == 7) begin
         c.w1 = '0;
         c.w2 = ($urandom_range(1, 0) == 0) ? '0 : mass_type'($urandom);
      end
      if (kind == 8) c.w2 = '0;
      c.rest = ($urandom_range(1, 0) == 0) ? rest_type'($urandom)
                                           : rest_type'($urandom_range(int'(spread), 0));
      c.bend = ($urandom_range(1, 0) == 1);
      c.wait_drain = 1'b0;
      return c;
   endfunction

   initial begin
      constraint_type c;
      // directed corners
      queue_constraint(make_constraint(0, 0, 0, 65536, 0, 0, 4096, 4096, 0, 0));
      queue_constraint(make_constraint(0, 0, 0, 65536, 0, 0, 4096, 4096, 0, 1));
      queue_constraint(make_constraint(0, 0, 0, 0, 65536, 0, 65535, 0, 131072, 0));
      queue_constraint(make_constraint(0, 0, 0, 0, 0, 65536, 0, 65535, 32768, 1));
      queue_constraint(make_constraint(5, 6, 7, 5, 6, 7, 4096, 4096, 1000, 0));
      queue_constraint(make_constraint(1, 2, 3, 9, 8, 7, 0, 0, 1000, 1));
      queue_constraint(make_constraint(8388607, 8388607, 8388607,
         -8388608, -8388608, -8388608, 65535, 65535, 8388607, 0));
      queue_constraint(make_constraint(8388607, 8388607, 8388607,
         -8388608, -8388608, -8388608, 65535, 65535, 0, 0));
      queue_constraint(make_constraint(8388607, 0, 0, 8388606, 0, 0,
         65535, 65535, 8388607, 0));
      queue_constraint(make_constraint(-8388608, 0, 0, -8388607, 0, 0,
         65535, 1, 8388607, 1));
      queue_constraint(make_constraint(1, 0, 0, 0, 0, 0, 1, 1, 0, 0));
      queue_constraint(make_constraint(-1, -1, -1, 1, 1, 1, 1, 65535, 8388607, 1));
      queue_constraint(make_constraint(100000, -200000, 300000,
         -50000, 70000, -90000, 12000, 3000, 200000, 0));
      queue_constraint(make_constraint(100000, -200000, 300000,
         -50000, 70000, -90000, 12000, 3000, 200000, 1));
      queue_constraint(make_constraint(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      for (int n = 0; n < 400; n++) begin
         c = random_constraint();
         if (n == 250) c.wait_drain = 1'b1;
         queue_constraint(c);
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (pending_constraints.size() != 0 || req_valid) @(posedge clock);
      while (expected_projections.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_projections.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule

### filelist.f
hdl/dcp_pkg.sv
hdl/dcp_sqrt.sv
hdl/dcp_div.sv
hdl/distance_constraint_projection_unit.sv
bench/testbench.sv
